@@ rtl/core/mpct_pkg.sv @@
// Package for the mouse packet cursor tracker.
// Holds the shared types, status bit positions and register indexes.
// No dependencies; compile before every other file of the block.
package mpct_pkg;

   // Bit positions inside the packet's status byte.
   localparam int STATUS_LEFT_BIT   = 0;
   localparam int STATUS_RIGHT_BIT  = 1;
   localparam int STATUS_MIDDLE_BIT = 2;
   localparam int STATUS_XOVF_BIT   = 6;
   localparam int STATUS_YOVF_BIT   = 7;

   // Default screen limits (width and height minus one).
   localparam int X_LIMIT_DEFAULT = 1280 - 1;
   localparam int Y_LIMIT_DEFAULT = 720 - 1;

   // Cursor position after reset.
   localparam int POS_X_DEFAULT = 5;
   localparam int POS_Y_DEFAULT = 2;

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_CNT_BITS = 2;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_X_LIMIT = 1'b0,
      CSR_Y_LIMIT = 1'b1
   } csr_index_type;

   // Place of the next byte within a packet.
   typedef enum logic [1:0] {
      POS_STATUS = 2'd0,
      POS_X_MOVE = 2'd1,
      POS_Y_MOVE = 2'd2
   } byte_pos_type;

   // One complete packet, as handed from the front to the back.
   typedef struct packed {
      logic [7:0] status;
      logic [7:0] x_move;
      logic [7:0] y_move;
   } move_cmd_type;

   typedef struct packed {
      logic         push;
      move_cmd_type cmd;
   } queue_push_type;

   typedef struct packed {
      logic         valid;
      move_cmd_type cmd;
   } queue_head_type;

endpackage

@@ rtl/core/mpct_if.sv @@
// Channel interfaces of the mouse packet cursor tracker.
// The request channel carries raw bytes, the response channel cursor results.
// No dependencies.
interface mpct_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface mpct_rsp_if #(
   parameter int COORD_BITS = 11
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] cursor_x;
   logic [COORD_BITS-1:0] cursor_y;
   logic                  btn_left;
   logic                  btn_right;
   logic                  btn_middle;
   logic                  ovf_x;
   logic                  ovf_y;

   modport source (output valid, output cursor_x, output cursor_y, output btn_left,
                   output btn_right, output btn_middle, output ovf_x,
                   output ovf_y, input ready);
   modport sink   (input valid, input cursor_x, input cursor_y, input btn_left,
                   input btn_right, input btn_middle, input ovf_x,
                   input ovf_y, output ready);
endinterface

@@ rtl/core/mpct_front.sv @@
// Front part of the cursor tracker: takes bytes and assembles packets.
// Depends on mpct_pkg and mpct_req_if; feeds mpct_queue.
module mpct_front (
   input  logic                    clock,
   input  logic                    reset,
   mpct_req_if.sink                req_ch,
   input  logic                    queue_full,
   output mpct_pkg::queue_push_type push_out
);
   import mpct_pkg::*;

   byte_pos_type pos_ff, pos_in;
   logic [7:0]   status_ff, status_in;
   logic [7:0]   x_move_ff, x_move_in;
   logic         accept;
   logic         take_status;
   logic         take_x_move;
   logic         take_y_move;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && !queue_full;

   // Next byte position.
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         unique case (pos_ff)
            POS_STATUS: pos_in = POS_X_MOVE;
            POS_X_MOVE: pos_in = POS_Y_MOVE;
            POS_Y_MOVE: pos_in = POS_STATUS;
            default:    pos_in = POS_X_MOVE;   // unreachable code behaves as a status byte
         endcase
      end
   end

   // Actions for the byte at hand.
   always_comb begin
      take_status = 1'b0;
      take_x_move = 1'b0;
      take_y_move = 1'b0;
      unique case (pos_ff)
         POS_X_MOVE: take_x_move = accept;
         POS_Y_MOVE: take_y_move = accept;
         default:    take_status = accept;
      endcase
   end

   assign status_in = take_status ? req_ch.data_byte : status_ff;
   assign x_move_in = take_x_move ? req_ch.data_byte : x_move_ff;

   assign push_out.push       = take_y_move;
   assign push_out.cmd.status = status_ff;
   assign push_out.cmd.x_move = x_move_ff;
   assign push_out.cmd.y_move = req_ch.data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_STATUS;
         status_ff <= '0;
         x_move_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         status_ff <= status_in;
         x_move_ff <= x_move_in;
      end
   end

endmodule

@@ rtl/core/mpct_queue.sv @@
// Short command queue between the front and the back of the tracker.
// Depends on mpct_pkg.
module mpct_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  mpct_pkg::queue_push_type push_in,
   output logic                    full,
   output mpct_pkg::queue_head_type head,
   input  logic                    pop
);
   import mpct_pkg::*;

   move_cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]   count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   assign full       = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   assign do_push = push_in.push && !full;
   assign do_pop  = pop && head.valid;

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_in.cmd;
      end
   end

endmodule

@@ rtl/core/mpct_back.sv @@
// Back part of the tracker: applies packets to the cursor and clamps it.
// Depends on mpct_pkg and mpct_rsp_if; drains mpct_queue.
module mpct_back #(
   parameter int COORD_BITS = 11
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mpct_pkg::queue_head_type head,
   output logic                     pop,
   input  logic [COORD_BITS-1:0]    x_limit,
   input  logic [COORD_BITS-1:0]    y_limit,
   mpct_rsp_if.source               rsp_ch
);
   import mpct_pkg::*;

   localparam int SUM_BITS = COORD_BITS + 2;

   logic [COORD_BITS-1:0]      pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0]      pos_y_ff, pos_y_in;
   logic                       valid_ff, valid_in;
   logic [7:0]                 status_ff;
   logic signed [7:0]          x_move;
   logic signed [7:0]          y_move;
   logic signed [SUM_BITS-1:0] sum_x;
   logic signed [SUM_BITS-1:0] sum_y;

   assign pop    = head.valid && (!valid_ff || rsp_ch.ready);
   assign x_move = head.cmd.x_move;
   assign y_move = head.cmd.y_move;

   assign sum_x = $signed({2'b00, pos_x_ff}) + SUM_BITS'(x_move);
   assign sum_y = $signed({2'b00, pos_y_ff}) - SUM_BITS'(y_move);

   // Clamp each coordinate to zero and its limit.
   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      if (pop) begin
         priority if (sum_x[SUM_BITS-1]) begin
            pos_x_in = '0;
         end else if (sum_x[SUM_BITS-2:0] > {1'b0, x_limit}) begin
            pos_x_in = x_limit;
         end else begin
            pos_x_in = sum_x[COORD_BITS-1:0];
         end
         priority if (sum_y[SUM_BITS-1]) begin
            pos_y_in = '0;
         end else if (sum_y[SUM_BITS-2:0] > {1'b0, y_limit}) begin
            pos_y_in = y_limit;
         end else begin
            pos_y_in = sum_y[COORD_BITS-1:0];
         end
      end
   end

   assign valid_in = pop || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= COORD_BITS'(POS_X_DEFAULT);
         pos_y_ff <= COORD_BITS'(POS_Y_DEFAULT);
         valid_ff <= 1'b0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= head.cmd.status;
      end
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.cursor_x   = pos_x_ff;
   assign rsp_ch.cursor_y   = pos_y_ff;
   assign rsp_ch.btn_left   = status_ff[STATUS_LEFT_BIT];
   assign rsp_ch.btn_right  = status_ff[STATUS_RIGHT_BIT];
   assign rsp_ch.btn_middle = status_ff[STATUS_MIDDLE_BIT];
   assign rsp_ch.ovf_x      = status_ff[STATUS_XOVF_BIT];
   assign rsp_ch.ovf_y      = status_ff[STATUS_YOVF_BIT];

endmodule

@@ rtl/core/mouse_packet_cursor_tracker.sv @@
// Top level of the mouse packet cursor tracker.
// Depends on mpct_pkg, mpct_if, mpct_front, mpct_queue and mpct_back.
//
// The block takes the raw byte stream of a three-byte PS/2 mouse and keeps a
// cursor position. Each beat on the request channel carries one received byte;
// the first byte of a packet is the status byte, the second the X movement and
// the third the Y movement, both read as 8-bit two's complement. On the third
// byte one beat leaves on the response channel: the cursor moved right by the X
// movement and up (Y decreasing) by the Y movement, each coordinate clamped to
// zero and its limit register, together with the button and overflow bits of
// that packet's status byte. The overflow bits are only reported; movement is
// always applied as received. Bytes are accepted one per cycle for as long as
// the two-entry packet queue between the byte front and the cursor back has
// room, so one result leaves for every three bytes; a result passes through
// the queue entry and then the output register after its third byte is
// accepted. The output register lets a new byte be taken while a result still
// waits. The limit registers are written through the csr_ port (index 0 for X,
// 1 for Y); the user must write them only while no packet is in flight, as
// the block does not enforce it. A lowered limit applies from the next packet.
// After reset the cursor sits at (5, 2) and the limits are 1279 and 719, all
// taken modulo two to the power COORD_BITS.
module mouse_packet_cursor_tracker #(
   parameter int COORD_BITS = 11
) (
   input  logic                           clock,
   input  logic                           reset,
   mpct_req_if.sink                       req_ch,
   mpct_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  mpct_pkg::csr_index_type        csr_index,
   input  logic [COORD_BITS-1:0]          csr_wdata
);
   import mpct_pkg::*;

   logic [COORD_BITS-1:0] x_limit_ff, x_limit_in;
   logic [COORD_BITS-1:0] y_limit_ff, y_limit_in;
   queue_push_type        queue_push;
   queue_head_type        queue_head;
   logic                  queue_full;
   logic                  queue_pop;

   // Limit registers. The user writes them only while the block is idle; the block does not enforce it.
   always_comb begin
      x_limit_in = x_limit_ff;
      y_limit_in = y_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_X_LIMIT: x_limit_in = csr_wdata;
            CSR_Y_LIMIT: y_limit_in = csr_wdata;
            default: begin
               x_limit_in = x_limit_ff;
               y_limit_in = y_limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff <= COORD_BITS'(X_LIMIT_DEFAULT);
         y_limit_ff <= COORD_BITS'(Y_LIMIT_DEFAULT);
      end else begin
         x_limit_ff <= x_limit_in;
         y_limit_ff <= y_limit_in;
      end
   end

   // Front: counts bytes within a packet and hands over complete packets.
   mpct_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push_out   (queue_push)
   );

   // Packet queue, so that a stalled response does not stop byte intake at once.
   mpct_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (queue_push),
      .full    (queue_full),
      .head    (queue_head),
      .pop     (queue_pop)
   );

   // Back: moves and clamps the cursor and holds the result beat.
   mpct_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (queue_head),
      .pop     (queue_pop),
      .x_limit (x_limit_ff),
      .y_limit (y_limit_ff),
      .rsp_ch  (rsp_ch)
   );

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the mouse packet cursor tracker.
// Uses mpct_pkg, the mpct_req_if and mpct_rsp_if channels and the top level,
// which are compiled ahead of this file.
`timescale 1ns / 1ps

module tb_top;
   import mpct_pkg::*;

   localparam int COORD_BITS    = 11;
   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 7;
   // A result leaves through the queue and the output register after its third
   // byte; the margin lets any byte still moving through the front settle.
   localparam int SETTLE_CYCLES = 8;
   // Several times the slowest correct run: about six hundred bytes, each
   // behind the longest sender gaps and receiver stalls of the busiest phase.
   localparam int CYCLE_LIMIT   = 200000;

   typedef logic [COORD_BITS-1:0] coord_type;

   // One byte waiting to be driven. A held byte is not offered until every
   // cursor result that is still owed has arrived.
   typedef struct {
      logic [7:0] data_byte;
      bit         hold;
   } mouse_byte_type;

   // One cursor result as it should appear on the response channel.
   typedef struct packed {
      coord_type cursor_x;
      coord_type cursor_y;
      logic      btn_left;
      logic      btn_right;
      logic      btn_middle;
      logic      ovf_x;
      logic      ovf_y;
   } cursor_beat_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_we;
   csr_index_type csr_index;
   coord_type     csr_wdata;

   mpct_req_if                           req_ch ();
   mpct_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_ch ();

   mouse_packet_cursor_tracker #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Bytes still to be driven, and cursor results that are owed by the block.
   mouse_byte_type  pending_byte_q[$];
   cursor_beat_type expected_cursor_q[$];

   // Our own copy of the tracker: packet position, the bytes held so far, the
   // cursor and the two limit registers. It starts where the block does after
   // reset.
   byte_pos_type pkt_pos      = POS_STATUS;
   logic [7:0]   status_hold  = 8'h00;
   logic [7:0]   x_move_hold  = 8'h00;
   coord_type    cursor_x_now = coord_type'(POS_X_DEFAULT);
   coord_type    cursor_y_now = coord_type'(POS_Y_DEFAULT);
   coord_type    x_limit_now;
   coord_type    y_limit_now;

   // Percentage of cycles in which each side holds back.
   int req_idle_pct;
   int rsp_idle_pct;

   int error_count = 0;
   int cycle_count = 0;

   always #HALF_PERIOD clock = ~clock;

   // Clamps a signed coordinate to the range zero up to the limit.
   function automatic coord_type clamp_coord(input int value, input coord_type limit);
      if (value < 0)
         return '0;
      if (value > int'(limit))
         return limit;
      return coord_type'(value);
   endfunction

   // Advances the tracker copy by one received byte. The third byte of a
   // packet moves the cursor and produces the result that the block owes.
   // The position code that is never used falls into the default branch and
   // is taken as the status byte, as the block would.
   function automatic void track_mouse_byte(input logic [7:0] rx_byte);
      int              dx;
      int              dy;
      cursor_beat_type beat;
      case (pkt_pos)
         POS_X_MOVE: begin
            x_move_hold = rx_byte;
            pkt_pos     = POS_Y_MOVE;
         end
         POS_Y_MOVE: begin
            // Both movements are plain 8-bit two's complement; the status
            // sign bits and overflow flags have no say in the movement.
            dx = int'($signed(x_move_hold));
            dy = int'($signed(rx_byte));
            cursor_x_now = clamp_coord(int'(cursor_x_now) + dx, x_limit_now);
            cursor_y_now = clamp_coord(int'(cursor_y_now) - dy, y_limit_now);
            beat.cursor_x   = cursor_x_now;
            beat.cursor_y   = cursor_y_now;
            beat.btn_left   = status_hold[STATUS_LEFT_BIT];
            beat.btn_right  = status_hold[STATUS_RIGHT_BIT];
            beat.btn_middle = status_hold[STATUS_MIDDLE_BIT];
            beat.ovf_x      = status_hold[STATUS_XOVF_BIT];
            beat.ovf_y      = status_hold[STATUS_YOVF_BIT];
            expected_cursor_q.push_back(beat);
            pkt_pos = POS_STATUS;
         end
         default: begin
            status_hold = rx_byte;
            pkt_pos     = POS_X_MOVE;
         end
      endcase
   endfunction

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endfunction

   // Picks one movement byte. Half are pushed in the drift direction so that
   // the cursor reaches both clamps; the rest are extremes or fully random.
   function automatic logic [7:0] pick_move(input int drift);
      case ($urandom_range(9))
         0, 1, 2: return 8'($urandom_range(255));
         3:       return 8'h7F;
         4:       return 8'h80;
         default: begin
            if (drift > 0)
               return 8'($urandom_range(127, 32));
            if (drift < 0)
               return 8'($urandom_range(224, 128));
            return 8'(int'($urandom_range(16)) - 8);
         end
      endcase
   endfunction

   task automatic queue_byte(input logic [7:0] value, input bit hold);
      mouse_byte_type item;
      item.data_byte = value;
      item.hold      = hold;
      pending_byte_q.push_back(item);
   endtask

   task automatic queue_packet(input logic [7:0] status, input logic [7:0] x_move,
                               input logic [7:0] y_move, input bit hold);
      queue_byte(status, hold);
      queue_byte(x_move, 1'b0);
      queue_byte(y_move, 1'b0);
   endtask

   // Fills the queue with about n_items bytes: mostly whole packets with
   // random content, now and then a stray byte that shifts the framing, and
   // once in a while a packet that waits until the block has gone quiet.
   task automatic queue_random(input int n_items, input int drift_x, input int drift_y);
      int added;
      added = 0;
      while (added < n_items) begin
         if ($urandom_range(9) == 0) begin
            queue_byte(8'($urandom_range(255)), 1'b0);
            added += 1;
         end else begin
            // A positive Y drift means a growing cursor Y, so the byte that
            // is subtracted has to lean negative.
            queue_packet(8'($urandom_range(255)), pick_move(drift_x), pick_move(-drift_y),
                         $urandom_range(39) == 0);
            added += 3;
         end
      end
   endtask

   // Waits until every byte has been taken and every result has come back,
   // then lets the front settle. Checked on the falling edge so that the
   // driver's updates from the rising edge are already visible.
   task automatic wait_for_quiet();
      do
         @(negedge clock);
      while (pending_byte_q.size() != 0 || req_ch.valid || expected_cursor_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one limit register while the block is quiet and mirrors it in
   // the tracker copy.
   task automatic write_limit(input csr_index_type index, input coord_type value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_X_LIMIT: x_limit_now = value;
         CSR_Y_LIMIT: y_limit_now = value;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Byte driver. A new beat is offered only once the previous one has been
   // taken, so valid never drops while a byte is waiting.
   always @(posedge clock) begin
      mouse_byte_type next_item;
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.data_byte <= 8'h00;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_byte_q.size() != 0 &&
             !(pending_byte_q[0].hold && (req_ch.valid || expected_cursor_q.size() != 0)) &&
             $urandom_range(99) >= req_idle_pct) begin
            next_item = pending_byte_q.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.data_byte <= next_item.data_byte;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result receiver: stalls at random according to the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Every byte beat that the block takes is fed to the tracker copy.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         track_mouse_byte(req_ch.data_byte);
      end
   end

   // Every result beat is checked against the oldest owed result.
   always @(posedge clock) begin
      cursor_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_cursor_q.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual x %0d y %0d",
                     $time, rsp_ch.cursor_x, rsp_ch.cursor_y);
            error_count++;
         end else begin
            want = expected_cursor_q.pop_front();
            check_field("cursor_x", int'(want.cursor_x), int'(rsp_ch.cursor_x));
            check_field("cursor_y", int'(want.cursor_y), int'(rsp_ch.cursor_y));
            check_field("btn_left", int'(want.btn_left), int'(rsp_ch.btn_left));
            check_field("btn_right", int'(want.btn_right), int'(rsp_ch.btn_right));
            check_field("btn_middle", int'(want.btn_middle), int'(rsp_ch.btn_middle));
            check_field("ovf_x", int'(want.ovf_x), int'(rsp_ch.ovf_x));
            check_field("ovf_y", int'(want.ovf_y), int'(rsp_ch.ovf_y));
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[mouse_packet_cursor_tracker] ERROR");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = CSR_X_LIMIT;
      csr_wdata    = '0;
      req_idle_pct = 25;
      rsp_idle_pct = 62;
      x_limit_now  = coord_type'(X_LIMIT_DEFAULT);
      y_limit_now  = coord_type'(Y_LIMIT_DEFAULT);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed packets at the reset limits. Each status bit is seen alone,
      // the unused status bits are set without effect, both movement bytes
      // go through their extremes and the cursor is driven into the zero
      // clamp, with an overflow flag set while movement is still applied.
      queue_packet(8'h01, 8'h00, 8'h00, 1'b0);
      queue_packet(8'h02, 8'h7F, 8'h80, 1'b0);
      queue_packet(8'h04, 8'h80, 8'h7F, 1'b0);
      queue_packet(8'h40, 8'h80, 8'h7F, 1'b0);
      queue_packet(8'h80, 8'hFF, 8'h01, 1'b0);
      queue_packet(8'h38, 8'h01, 8'hFF, 1'b0);
      queue_packet(8'hFF, 8'h7F, 8'h80, 1'b0);
      queue_packet(8'h00, 8'h7F, 8'h80, 1'b0);
      wait_for_quiet();

      // Widest limits, with the cursor pushed towards the far corner. The
      // packet in the middle waits for every owed result before it is
      // offered, while earlier packets are still on their way.
      write_limit(CSR_X_LIMIT, coord_type'(2047));
      write_limit(CSR_Y_LIMIT, coord_type'(2047));
      queue_random(55, 1, 1);
      queue_packet(8'h00, 8'h7F, 8'h80, 1'b1);
      queue_random(55, 1, 1);
      wait_for_quiet();

      // The sender now idles more than the receiver.
      req_idle_pct = 62;
      rsp_idle_pct = 25;

      // Limits lowered below the cursor: a still packet must pull the
      // cursor down to the new limits.
      write_limit(CSR_X_LIMIT, coord_type'(100));
      write_limit(CSR_Y_LIMIT, coord_type'(50));
      queue_packet(8'h00, 8'h00, 8'h00, 1'b0);
      queue_random(110, -1, -1);
      wait_for_quiet();

      // Zero limits pin the cursor to the origin whatever the movement.
      write_limit(CSR_X_LIMIT, coord_type'(0));
      write_limit(CSR_Y_LIMIT, coord_type'(0));
      queue_random(60, 1, 1);
      wait_for_quiet();

      // No idling from here on.
      req_idle_pct = 0;
      rsp_idle_pct = 0;

      write_limit(CSR_X_LIMIT, coord_type'($urandom_range(2047)));
      write_limit(CSR_Y_LIMIT, coord_type'($urandom_range(2047)));
      queue_random(110, 0, 0);
      wait_for_quiet();

      // Mixed extremes: X may run across the whole range while Y is pinned.
      write_limit(CSR_X_LIMIT, coord_type'(2047));
      write_limit(CSR_Y_LIMIT, coord_type'(0));
      queue_random(160, 1, -1);
      wait_for_quiet();

      if (error_count == 0) begin
         $display("[mouse_packet_cursor_tracker] OK");
      end else begin
         $display("[mouse_packet_cursor_tracker] ERROR");
      end
      $finish;
   end

endmodule
